/* rtl/core/gtq_pkg.sv */
package gtq_pkg;

  // Default sizes
  localparam int GROUP_COUNT_DEF  = 16;
  localparam int MEMBER_SLOTS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF  = 64;
  localparam int VALUE_BITS_DEF   = 32;

  // Operation codes
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_UNKNOWN    = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_ENQ,
    S_DEQ,
    S_DONE
  } gtq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic       take;
    logic       load;
    logic       scan_start;
    logic       scan_step;
    logic       alloc;
    logic       enq;
    logic       deq_rd;
    logic       deq;
    logic       set_res;
    logic [2:0] res_code;
  } gtq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic m_full;
    logic q_empty;
    logic q_full;
    logic scan_last;
    logic hit;
  } gtq_sts_t;

endpackage

/* rtl/core/gtq_ctrl.sv */
module gtq_ctrl import gtq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] op,
  output logic       result_valid,
  input  logic       result_stall,
  input  gtq_sts_t   sts,
  output gtq_cmd_t   cmd
);

  gtq_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    item_stall   = (state != S_IDLE);
    result_valid = (state == S_DONE);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.take = 1'b1;
          case (op)
            OP_LOAD: begin
              cmd.load     = 1'b1;
              cmd.set_res  = 1'b1;
              cmd.res_code = sts.m_full ? ST_TABLE_FULL : ST_OK;
              state_next   = S_DONE;
            end
            OP_DEQ: begin
              if (sts.q_empty) begin
                cmd.set_res  = 1'b1;
                cmd.res_code = ST_EMPTY;
                state_next   = S_DONE;
              end else begin
                cmd.deq_rd = 1'b1;
                state_next = S_DEQ;
              end
            end
            OP_ENQ: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            default: begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_OK;
              state_next   = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_ALLOC;
      end
      S_ALLOC: begin
        if (!sts.hit) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_UNKNOWN;
          state_next   = S_DONE;
        end else if (sts.q_full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_FULL;
          state_next   = S_DONE;
        end else begin
          cmd.alloc  = 1'b1;
          state_next = S_ENQ;
        end
      end
      S_ENQ: begin
        cmd.enq      = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_OK;
        state_next   = S_DONE;
      end
      S_DEQ: begin
        cmd.deq      = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_OK;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!result_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/gtq_dp.sv */
module gtq_dp import gtq_pkg::*; #(
  parameter int GROUP_COUNT  = GROUP_COUNT_DEF,
  parameter int MEMBER_SLOTS = MEMBER_SLOTS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  gtq_cmd_t    cmd,
  output gtq_sts_t    sts,
  input  logic [31:0] value,
  input  logic [3:0]  group,
  output logic [31:0] out_value,
  output logic [2:0]  status
);

  localparam int GW  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int MIW = (MEMBER_SLOTS > 1) ? $clog2(MEMBER_SLOTS) : 1;
  localparam int MCW = $clog2(MEMBER_SLOTS + 1);
  localparam int NW  = $clog2(QUEUE_DEPTH);
  localparam int TW  = $clog2(QUEUE_DEPTH + 1);
  localparam int VB  = VALUE_BITS;

  // Group number reduced modulo group count, as a constant table
  logic [GW-1:0] gmod [16];
  for (genvar i = 0; i < 16; i++) begin : g_mod
    assign gmod[i] = GW'(i % GROUP_COUNT);
  end

  // Item value
  logic [VB-1:0] vreg;
  always_ff @(posedge clk) begin
    if (cmd.take) vreg <= VB'(value);
  end

  // Membership table
  logic [VB-1:0]  mval [MEMBER_SLOTS];
  logic [GW-1:0]  mgrp [MEMBER_SLOTS];
  logic [MCW-1:0] mcount;
  logic [VB-1:0]  mval_q;
  logic [GW-1:0]  mgrp_q;
  logic [MCW-1:0] scnt;
  logic [MIW-1:0] maddr;
  logic           mrd;
  logic           hit;
  logic [GW-1:0]  best;

  assign sts.m_full    = (mcount >= MCW'(MEMBER_SLOTS));
  assign sts.scan_last = (scnt >= mcount);
  assign sts.hit       = hit;

  assign maddr = cmd.scan_start ? '0 : scnt[MIW-1:0];
  assign mrd   = cmd.scan_start || (cmd.scan_step && (scnt < MCW'(MEMBER_SLOTS)));

  always_ff @(posedge clk) begin
    if (cmd.load && !sts.m_full) begin
      mval[mcount[MIW-1:0]] <= VB'(value);
      mgrp[mcount[MIW-1:0]] <= gmod[group];
    end
    if (mrd) begin
      mval_q <= mval[maddr];
      mgrp_q <= mgrp[maddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mcount <= '0;
    end else if (cmd.load && !sts.m_full) begin
      mcount <= mcount + MCW'(1);
    end
  end

  // Lookup scan, one entry a cycle, lowest group wins
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scnt <= MCW'(1);
      hit  <= 1'b0;
      best <= '0;
    end else if (cmd.scan_step) begin
      if (scnt < MCW'(MEMBER_SLOTS)) scnt <= scnt + MCW'(1);
      if ((scnt <= mcount) && (mval_q == vreg) && (!hit || (mgrp_q < best))) begin
        hit  <= 1'b1;
        best <= mgrp_q;
      end
    end
  end

  // Free stack; an entry never pushed holds its own index
  logic [NW-1:0]          stk [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] svld;
  logic [TW-1:0]          top;
  logic [TW-1:0]          tm1;
  logic [NW-1:0]          stk_q;
  logic [NW-1:0]          node_new;

  assign tm1         = top - TW'(1);
  assign sts.q_empty = (top == TW'(QUEUE_DEPTH));
  assign sts.q_full  = (top == '0);
  assign node_new    = svld[tm1[NW-1:0]] ? stk_q : tm1[NW-1:0];

  // Group pointers and order ring
  logic [NW-1:0]          gfirst [GROUP_COUNT];
  logic [NW-1:0]          glast  [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] gpres;
  logic [GW-1:0]          ring   [GROUP_COUNT];
  logic [GW-1:0]          ord_rd;
  logic [GW-1:0]          ord_wr;
  logic [GW-1:0]          greg;
  logic [NW-1:0]          dnode;
  logic [GW-1:0]          ghead;

  assign ghead = ring[ord_rd];

  function automatic logic [GW-1:0] ring_next(input logic [GW-1:0] p);
    ring_next = (p == GW'(GROUP_COUNT - 1)) ? '0 : p + GW'(1);
  endfunction

  // Linked store
  logic [VB-1:0] eval [QUEUE_DEPTH];
  logic [NW-1:0] elink [QUEUE_DEPTH];
  logic [VB-1:0] eval_q;
  logic [NW-1:0] elink_q;

  always_ff @(posedge clk) begin
    if (cmd.deq_rd) begin
      eval_q  <= eval[gfirst[ghead]];
      elink_q <= elink[gfirst[ghead]];
    end
    if (cmd.enq) begin
      eval[node_new] <= vreg;
      if (gpres[greg]) elink[glast[greg]] <= node_new;
    end
  end

  // Stack memory
  always_ff @(posedge clk) begin
    if (cmd.alloc) stk_q <= stk[tm1[NW-1:0]];
    if (cmd.deq) stk[top[NW-1:0]] <= dnode;
  end

  // Head and tail bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.alloc) greg <= best;
    if (cmd.deq_rd) begin
      greg  <= ghead;
      dnode <= gfirst[ghead];
    end
    if (cmd.enq) begin
      glast[greg] <= node_new;
      if (!gpres[greg]) begin
        gfirst[greg] <= node_new;
        ring[ord_wr] <= greg;
      end
    end
    if (cmd.deq && (dnode != glast[greg])) gfirst[greg] <= elink_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top    <= TW'(QUEUE_DEPTH);
      svld   <= '0;
      gpres  <= '0;
      ord_rd <= '0;
      ord_wr <= '0;
    end else begin
      if (cmd.enq) begin
        top <= tm1;
        if (!gpres[greg]) begin
          gpres[greg] <= 1'b1;
          ord_wr      <= ring_next(ord_wr);
        end
      end
      if (cmd.deq) begin
        top              <= top + TW'(1);
        svld[top[NW-1:0]] <= 1'b1;
        if (dnode == glast[greg]) begin
          gpres[greg] <= 1'b0;
          ord_rd      <= ring_next(ord_rd);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      out_value <= cmd.deq ? 32'(eval_q) : '0;
      status    <= cmd.res_code;
    end
  end

  // Checks
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top <= TW'(QUEUE_DEPTH)) else $error("free stack top out of range");
  a_mcount_range: assert property (@(posedge clk) disable iff (rst)
    mcount <= MCW'(MEMBER_SLOTS)) else $error("member count out of range");
  a_empty_no_group: assert property (@(posedge clk) disable iff (rst)
    (top == TW'(QUEUE_DEPTH)) |-> (gpres == '0)) else $error("group present in empty queue");
  a_enq_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.enq |-> (top != '0)) else $error("enqueue with no free entry");

endmodule

/* rtl/core/grouped_team_queue_unit.sv */
// Team queue. Values are mapped to groups by a membership table; an enqueued
// value goes right behind the last queued member of its group, or at the tail.
//
// Channels: item (op, value, group) with item_valid/item_stall, and result
// (out_value, status) with result_valid/result_stall. Every item produces
// exactly one result. One item is processed at a time.
//
// Steps from item transfer to result valid:
//   load, unused op, empty dequeue : result set directly
//   dequeue                        : head read, then pop
//   enqueue                        : member scan, free entry allocation, link
//                                    (unknown or full: ends after the scan)
// Enqueue time is set by the membership lookup, which reads the member
// table one entry per cycle through its single read port. A new item is
// taken only once the result of the last one has been accepted.
//
// Reset clears the membership table, the queue and the free list; no
// clearing pass is needed. While the result is stalled it holds and no new
// item is taken.
module grouped_team_queue_unit import gtq_pkg::*; #(
  parameter int GROUP_COUNT  = GROUP_COUNT_DEF,
  parameter int MEMBER_SLOTS = MEMBER_SLOTS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [31:0] value,
  input  logic [3:0]  group,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] out_value,
  output logic [2:0]  status
);

  gtq_cmd_t cmd;
  gtq_sts_t sts;

  // Sequencer
  gtq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Tables, linked store and result register
  gtq_dp #(
    .GROUP_COUNT  (GROUP_COUNT),
    .MEMBER_SLOTS (MEMBER_SLOTS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .group     (group),
    .out_value (out_value),
    .status    (status)
  );

endmodule
